// ===== sv/ppubam_pkg.sv =====
// ----------------------------------------------------------------------------
// ppubam_pkg
// Types and codes shared by the picture-bus address map.
// ----------------------------------------------------------------------------
package ppubam_pkg;

    typedef enum logic [1:0] {
        REGION_PATTERN = 2'd0,
        REGION_TABLE   = 2'd1,
        REGION_PALETTE = 2'd2,
        REGION_OPEN    = 2'd3
    } region_t;

    typedef logic [2:0] mirror_t;

    localparam mirror_t MIRROR_SINGLE_LOW  = 3'd0;
    localparam mirror_t MIRROR_SINGLE_HIGH = 3'd1;
    localparam mirror_t MIRROR_PAIR_A10    = 3'd2;
    localparam mirror_t MIRROR_PAIR_A11    = 3'd3;

    localparam logic CFG_MIRRORING = 1'b0;
    localparam logic CFG_PATTERN_WR = 1'b1;

    localparam logic ACCESS_WRITE = 1'b1;

    localparam int TABLE_DEPTH   = 2048;
    localparam int PALETTE_DEPTH = 32;

endpackage

// ===== sv/ppubam_ram.sv =====
// ----------------------------------------------------------------------------
// ppubam_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ppubam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata <= mem_reg[addr];
            end
        end
    end

endmodule

// ===== sv/ppu_bus_address_map_top.sv =====
// ----------------------------------------------------------------------------
// ppu_bus_address_map_top
// Picture-bus memory map: pattern, name-table and palette memories.
// An accepted request passes the RAM stage, then the output register.
// Throughput: 1 request per cycle unless stalled; RAMs are single-port.
// Reset clears valid flags and loads mirroring mode 3, pattern write off.
// Memory contents are not cleared by reset.
// ----------------------------------------------------------------------------
module ppu_bus_address_map_top
    import ppubam_pkg::*;
#(
    parameter int PATTERN_DEPTH = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [2:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [15:0] bus_address,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic [1:0]  region
);

    localparam int PAW       = $clog2(PATTERN_DEPTH);
    localparam int PAT_FOLDS = (8192 + PATTERN_DEPTH - 1) / PATTERN_DEPTH;
    localparam int TAW       = $clog2(TABLE_DEPTH);
    localparam int PLAW      = $clog2(PALETTE_DEPTH);

    mirror_t     mirror_reg;
    logic        pat_wr_reg;

    logic        s1_valid_reg;
    logic        s1_read_reg;
    logic        s1_extra_reg;
    region_t     s1_region_reg;

    logic        out_valid_reg;
    logic [7:0]  read_data_reg;
    region_t     region_reg;
    logic [7:0]  read_data_next;

    logic        in_accept;
    logic        s2_free;
    logic        is_write;
    region_t     in_region;
    logic [12:0] pat_full;
    logic [PAW-1:0] pat_idx;
    logic [TAW-1:0] tab_idx;
    logic        tab_extra;
    logic [PLAW-1:0] pal_idx;

    logic        pat_en;
    logic        low_en;
    logic        ext_en;
    logic        pal_en;
    logic [7:0]  pat_rdata;
    logic [7:0]  low_rdata;
    logic [7:0]  ext_rdata;
    logic [7:0]  pal_rdata;

    assign s2_free   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !s2_free;
    assign in_accept = in_valid && !in_stall;
    assign is_write  = (mode == ACCESS_WRITE);

    always_comb
    begin
        if (bus_address[15:14] != 2'b00)
        begin
            in_region = REGION_OPEN;
        end
        else if (!bus_address[13])
        begin
            in_region = REGION_PATTERN;
        end
        else if (bus_address[13:8] == 6'h3F)
        begin
            in_region = REGION_PALETTE;
        end
        else
        begin
            in_region = REGION_TABLE;
        end
    end

    always_comb
    begin
        pat_full = bus_address[12:0];
        for (int k = 1; k < PAT_FOLDS; k++)
        begin
            if ({1'b0, bus_address[12:0]} >= 14'(k * PATTERN_DEPTH))
            begin
                pat_full = 13'(bus_address[12:0] - 13'(k * PATTERN_DEPTH));
            end
        end
    end

    assign pat_idx = pat_full[PAW-1:0];

    always_comb
    begin
        tab_extra = 1'b0;
        case (mirror_reg)
            MIRROR_SINGLE_LOW:  tab_idx = {1'b0, bus_address[9:0]};
            MIRROR_SINGLE_HIGH: tab_idx = {1'b1, bus_address[9:0]};
            MIRROR_PAIR_A10:    tab_idx = {bus_address[10], bus_address[9:0]};
            MIRROR_PAIR_A11:    tab_idx = {bus_address[11], bus_address[9:0]};
            default:
            begin
                tab_idx   = bus_address[10:0];
                tab_extra = bus_address[11];
            end
        endcase
    end

    always_comb
    begin
        pal_idx = bus_address[4:0];
        if (pal_idx[4] && (pal_idx[1:0] == 2'b00))
        begin
            pal_idx[4] = 1'b0;
        end
    end

    assign pat_en = in_accept && (in_region == REGION_PATTERN) && (!is_write || pat_wr_reg);
    assign low_en = in_accept && (in_region == REGION_TABLE) && !tab_extra;
    assign ext_en = in_accept && (in_region == REGION_TABLE) && tab_extra;
    assign pal_en = in_accept && (in_region == REGION_PALETTE);

    ppubam_ram #(.WIDTH(8), .DEPTH(PATTERN_DEPTH)) u_pattern (
        .clk   (clk),
        .en    (pat_en),
        .we    (is_write),
        .addr  (pat_idx),
        .wdata (write_data),
        .rdata (pat_rdata)
    );

    ppubam_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_table_low (
        .clk   (clk),
        .en    (low_en),
        .we    (is_write),
        .addr  (tab_idx),
        .wdata (write_data),
        .rdata (low_rdata)
    );

    ppubam_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_table_extra (
        .clk   (clk),
        .en    (ext_en),
        .we    (is_write),
        .addr  (tab_idx),
        .wdata (write_data),
        .rdata (ext_rdata)
    );

    ppubam_ram #(.WIDTH(8), .DEPTH(PALETTE_DEPTH)) u_palette (
        .clk   (clk),
        .en    (pal_en),
        .we    (is_write),
        .addr  (pal_idx),
        .wdata (write_data),
        .rdata (pal_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_reg <= MIRROR_PAIR_A11;
            pat_wr_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIRRORING:  mirror_reg <= cfg_data;
                CFG_PATTERN_WR: pat_wr_reg <= cfg_data[0];
                default:        pat_wr_reg <= pat_wr_reg;
            endcase
        end
    end

    // advance the RAM stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s2_free)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_read_reg   <= !is_write;
            s1_extra_reg  <= tab_extra;
            s1_region_reg <= in_region;
        end
    end

    always_comb
    begin
        read_data_next = 8'd0;
        if (s1_read_reg)
        begin
            case (s1_region_reg)
                REGION_PATTERN: read_data_next = pat_rdata;
                REGION_TABLE:   read_data_next = s1_extra_reg ? ext_rdata : low_rdata;
                REGION_PALETTE: read_data_next = pal_rdata;
                default:        read_data_next = 8'd0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_free && s1_valid_reg)
        begin
            read_data_reg <= read_data_next;
            region_reg    <= s1_region_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign region    = region_reg;

`ifndef SYNTHESIS
    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted request did not reach RAM stage");

    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && out_stall) |-> in_stall)
        else $error("request accepted while both stages are held");

    a_open_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (region_reg == REGION_OPEN)) |-> (read_data_reg == 8'd0))
        else $error("open-bus result carries nonzero data");
`endif

endmodule

// ===== tb/ppu_bus_address_map_checker.sv =====
// ----------------------------------------------------------------------------
// ppu_bus_address_map_checker
// Watches the request, result and register ports of the picture-bus address
// map. It keeps its own pattern, name-table and palette memories and its own
// copy of the mapping registers. For every accepted request it predicts the
// read data and region. Each accepted result is compared with the oldest
// prediction, one field at a time. It reports its error count and the number
// of results still owed.
// ----------------------------------------------------------------------------
module ppu_bus_address_map_checker
    import ppubam_pkg::*;
#(
    parameter int PATTERN_DEPTH = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [2:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        mode,
    input  logic [15:0] bus_address,
    input  logic [7:0]  write_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  read_data,
    input  logic [1:0]  region,
    output int          fails,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        region_t    area;
    } access_result_t;

    logic [7:0]     pattern_mem [PATTERN_DEPTH];
    logic [7:0]     table_low [TABLE_DEPTH];
    logic [7:0]     table_extra [TABLE_DEPTH];
    logic [7:0]     palette_mem [PALETTE_DEPTH];
    mirror_t        mirror;
    logic           pattern_wr;
    access_result_t predicted[$];
    access_result_t got;
    access_result_t want;
    int             err_count = 0;

    assign fails = err_count;

    function automatic access_result_t apply_access(input logic is_wr,
                                                    input logic [15:0] addr,
                                                    input logic [7:0] wd);
        access_result_t res;
        logic [1:0]     quad;
        logic [9:0]     ofs;
        logic [10:0]    slot;
        logic           use_extra;
        logic [4:0]     pal_idx;
        int             pat_idx;
        res.data = 8'h00;
        if (addr >= 16'h4000) begin
            res.area = REGION_OPEN;
        end
        else if (addr < 16'h2000) begin
            res.area = REGION_PATTERN;
            pat_idx  = int'(addr) % PATTERN_DEPTH;
            if (!is_wr)
                res.data = pattern_mem[pat_idx];
            else if (pattern_wr)
                pattern_mem[pat_idx] = wd;
        end
        else if (addr < 16'h3F00) begin
            res.area  = REGION_TABLE;
            quad      = addr[11:10];
            ofs       = addr[9:0];
            use_extra = 1'b0;
            case (mirror)
                MIRROR_SINGLE_LOW:  slot = {1'b0, ofs};
                MIRROR_SINGLE_HIGH: slot = {1'b1, ofs};
                MIRROR_PAIR_A10:    slot = {quad[0], ofs};
                MIRROR_PAIR_A11:    slot = {quad[1], ofs};
                default:
                begin
                    slot      = {quad[0], ofs};
                    use_extra = quad[1];
                end
            endcase
            if (use_extra) begin
                if (is_wr)
                    table_extra[slot] = wd;
                else
                    res.data = table_extra[slot];
            end
            else begin
                if (is_wr)
                    table_low[slot] = wd;
                else
                    res.data = table_low[slot];
            end
        end
        else begin
            res.area = REGION_PALETTE;
            pal_idx  = addr[4:0];
            if (pal_idx[4] && pal_idx[1:0] == 2'b00)
                pal_idx[4] = 1'b0;
            if (is_wr)
                palette_mem[pal_idx] = wd;
            else
                res.data = palette_mem[pal_idx];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            predicted.delete();
            mirror     = MIRROR_PAIR_A11;
            pattern_wr = 1'b0;
            pending   <= 0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == CFG_MIRRORING)
                    mirror = cfg_data;
                else
                    pattern_wr = cfg_data[0];
            end
            if (out_valid && !out_stall) begin
                got.data = read_data;
                got.area = region_t'(region);
                if (predicted.size() == 0) begin
                    $error("result with no request outstanding: read_data %0h region %0d",
                           read_data, region);
                    err_count++;
                end
                else begin
                    want = predicted.pop_front();
                    if (got.data !== want.data) begin
                        $error("read_data mismatch: expected %0h, actual %0h",
                               want.data, read_data);
                        err_count++;
                    end
                    if (got.area !== want.area) begin
                        $error("region mismatch: expected %0d, actual %0d",
                               want.area, region);
                        err_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predicted.push_back(apply_access(mode == ACCESS_WRITE, bus_address,
                                                 write_data));
            pending <= predicted.size();
        end
    end

endmodule

// ===== tb/ppu_bus_address_map_top_tb.sv =====
// ----------------------------------------------------------------------------
// ppu_bus_address_map_top_tb
// Drives read and write requests into the picture-bus address map and
// gives the verdict. It starts with a few requests under the reset mapping.
// It then fills a small window of every name-table quarter and the whole
// palette in four-screen mode and runs directed corner requests. After that
// come random phases over the mirroring modes, alternating pattern writes.
// Name-table requests stay inside the filled window, and pattern reads only
// target cells that have been written. Sender and receiver stall at random,
// with one long output hold-off and one drain pause. The checker does the
// prediction and the comparison.
// ----------------------------------------------------------------------------
module ppu_bus_address_map_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ppubam_pkg::*;

    localparam int      PAT_DEPTH          = 8192;
    localparam int      PHASES             = 10;
    localparam int      PHASE_ITEMS        = 110;
    localparam int      TABLE_SPAN         = 16;
    localparam int      LONG_HOLD          = 200;
    localparam mirror_t MIRROR_FOUR_SCREEN = 3'd4;
    localparam logic    ACCESS_READ        = ~ACCESS_WRITE;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [2:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        mode;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  read_data;
    logic [1:0]  region;
    int          fails;
    int          pending;

    int          send_idle_pct = 20;
    int          recv_idle_pct = 61;
    int          hold_asked    = 0;
    int          hold_given    = 0;
    logic        pattern_on    = 1'b0;
    logic        known_pat [PAT_DEPTH];
    logic [15:0] pat_addrs[$];

    ppu_bus_address_map_top #(
        .PATTERN_DEPTH(PAT_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .bus_address(bus_address),
        .write_data(write_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .read_data(read_data),
        .region(region)
    );

    ppu_bus_address_map_checker #(
        .PATTERN_DEPTH(PAT_DEPTH)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .bus_address(bus_address),
        .write_data(write_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .read_data(read_data),
        .region(region),
        .fails(fails),
        .pending(pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // hold the output for a long stretch on request, otherwise stall at random
    initial
    begin
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_asked != hold_given) begin
                hold_given = hold_asked;
                repeat (LONG_HOLD) begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_access(input logic m, input logic [15:0] a, input logic [7:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        bus_address <= a;
        write_data  <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (m == ACCESS_WRITE && a < 16'h2000 && pattern_on && !known_pat[a[12:0]]) begin
            known_pat[a[12:0]] = 1'b1;
            pat_addrs.push_back(a);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic configure(input mirror_t mir, input logic pw);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MIRRORING;
        cfg_data  <= mir;
        @(posedge clk);
        cfg_index <= CFG_PATTERN_WR;
        cfg_data  <= {2'b00, pw};
        @(posedge clk);
        cfg_we    <= 1'b0;
        pattern_on = pw;
    endtask

    task automatic random_access();
        int          pick;
        logic        m;
        logic [15:0] a;
        logic [7:0]  d;
        pick = $urandom_range(99);
        m    = 1'($urandom_range(1));
        d    = 8'($urandom_range(255));
        if (pick < 25) begin
            if (m == ACCESS_READ && pat_addrs.size() > 0) begin
                a = pat_addrs[$urandom_range(pat_addrs.size() - 1)];
            end
            else begin
                m = ACCESS_WRITE;
                a = 16'($urandom_range(16'h1FFF));
            end
        end
        else if (pick < 60) begin
            a      = 16'($urandom_range(16'h3EFF, 16'h2000));
            a[9:4] = 6'd0;
        end
        else if (pick < 80)
            a = 16'h3F00 | 16'($urandom_range(255));
        else
            a = 16'($urandom_range(16'hFFFF, 16'h4000));
        send_access(m, a, d);
    endtask

    initial
    begin
        foreach (known_pat[i])
            known_pat[i] = 1'b0;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= CFG_MIRRORING;
        cfg_data    <= 3'd0;
        in_valid    <= 1'b0;
        mode        <= ACCESS_READ;
        bus_address <= 16'h0000;
        write_data  <= 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset mapping: horizontal, pattern protected
        send_access(ACCESS_WRITE, 16'h2000, 8'hA5);
        send_access(ACCESS_READ, 16'h2400, 8'h00);
        send_access(ACCESS_WRITE, 16'h0000, 8'hFF);
        send_access(ACCESS_READ, 16'hFFFF, 8'hFF);
        send_access(ACCESS_WRITE, 16'h4000, 8'h5A);
        wait_drained();

        // fill the name-table window of every quarter and every palette cell
        configure(MIRROR_FOUR_SCREEN, 1'b1);
        for (int q = 0; q < 4; q++)
            for (int o = 0; o < TABLE_SPAN; o++)
                send_access(ACCESS_WRITE, 16'(32'h2000 + q * 32'h0400 + o),
                            8'($urandom_range(255)));
        for (int i = 16'h3F00; i < 16'h3F20; i++)
            send_access(ACCESS_WRITE, i[15:0], 8'($urandom_range(255)));

        send_access(ACCESS_WRITE, 16'h1FFF, 8'h00);
        send_access(ACCESS_READ, 16'h1FFF, 8'hFF);
        send_access(ACCESS_WRITE, 16'h0000, 8'hFF);
        send_access(ACCESS_READ, 16'h0000, 8'h00);
        send_access(ACCESS_WRITE, 16'h3F10, 8'h3C);
        send_access(ACCESS_READ, 16'h3F00, 8'h00);
        send_access(ACCESS_WRITE, 16'h3F1C, 8'hC3);
        send_access(ACCESS_READ, 16'h3FEC, 8'h00);
        send_access(ACCESS_READ, 16'h3FFF, 8'h00);
        send_access(ACCESS_WRITE, 16'h3EFF, 8'h81);
        send_access(ACCESS_READ, 16'h2EFF, 8'h00);
        send_access(ACCESS_READ, 16'h3800, 8'h00);
        send_access(ACCESS_READ, 16'h2C00, 8'h00);
        send_access(ACCESS_READ, 16'h8000, 8'h00);
        send_access(ACCESS_WRITE, 16'hFFFF, 8'hFF);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            if (p < 3) begin
                send_idle_pct = 20;
                recv_idle_pct = 61;
            end
            else if (p < 6) begin
                send_idle_pct = 61;
                recv_idle_pct = 20;
            end
            else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            configure(mirror_t'(p % 8), (p % 2) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 2 && k == PHASE_ITEMS / 2)
                    wait_drained();
                if (p == 6 && k == PHASE_ITEMS / 2)
                    hold_asked++;
                random_access();
            end
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
